[sv/sfcs_pkg.sv]
// Package with the shared types and constants of the SPI flash command sequencer.
package sfcs_pkg;

    localparam int unsigned PageBytes   = 256;
    localparam int unsigned SectorBytes = 4096;
    localparam int unsigned ChipBytes   = 524288;
    localparam int unsigned PageBits    = $clog2(PageBytes);
    localparam int unsigned ChunkW      = PageBits + 1;

    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_PROG  = 3'd1;
    localparam logic [2:0] CMD_ERASE = 3'd2;
    localparam logic [2:0] CMD_DATA  = 3'd3;
    localparam logic [2:0] CMD_REPLY = 3'd4;
    localparam logic [2:0] CMD_TICK  = 3'd5;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_PROG  = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;

    localparam logic [1:0] KIND_SPI  = 2'd0;
    localparam logic [1:0] KIND_RD   = 2'd1;
    localparam logic [1:0] KIND_WANT = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [7:0] SPI_READ  = 8'h03;
    localparam logic [7:0] SPI_PROG  = 8'h02;
    localparam logic [7:0] SPI_RDSR  = 8'h05;
    localparam logic [7:0] SPI_WREN  = 8'h06;
    localparam logic [7:0] SPI_SE    = 8'h20;
    localparam logic [7:0] SPI_DUMMY = 8'h00;
    localparam logic [7:0] BIT_WEL   = 8'h02;
    localparam logic [7:0] BIT_WIP   = 8'h01;

    localparam logic [15:0] POLL_RESET = 16'd10000;

    typedef enum logic [3:0] {
        PH_IDLE, PH_HDR, PH_RDATA, PH_PAYLOAD, PH_PDATA, PH_WREN,
        PH_POLLCMD, PH_POLLDATA, PH_POLLWAIT, PH_PROGWAIT
    } t_phase;

    typedef struct packed {
        logic [2:0]  command;
        logic [23:0] address;
        logic [19:0] length;
        logic [7:0]  data;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] spi_byte;
        logic       eot;
        logic [7:0] read_byte;
        logic [1:0] status;
    } t_result;

    // Up to three results of one item; count says how many are valid.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
        t_result    r2;
    } t_bundle;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QAddrW = $clog2(QDepth);

endpackage

[sv/sfcs_front.sv]
// Front part: accepts items, runs the flash command state machine and emits result bundles.
module sfcs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  sfcs_pkg::t_item   i_item,
    output logic              o_push,
    output sfcs_pkg::t_bundle o_bundle,
    input  logic              i_full
);
    sfcs_pkg::t_phase r_phase, n_phase;
    logic [1:0]  r_op, n_op;
    logic [23:0] r_addr, n_addr;
    logic [19:0] r_rem, n_rem;
    logic [sfcs_pkg::ChunkW-1:0] r_chunk, n_chunk;
    logic [1:0]  r_hdr, n_hdr;
    logic [15:0] r_poll, n_poll;
    logic        r_wel, n_wel;
    logic [15:0] r_limit;
    logic [15:0] limit_eff;
    logic [16:0] poll_inc;
    logic        take;
    sfcs_pkg::t_result res [3];
    logic [1:0]  cnt;
    logic [20:0] room_start, room_cur;
    logic [24:0] end_addr;

    assign o_ready   = !i_full;
    assign take      = i_valid && o_ready;
    assign limit_eff = (r_limit == 16'd0) ? 16'd1 : r_limit;
    assign poll_inc  = {1'b0, r_poll} + 17'd1;
    assign end_addr  = {1'b0, i_item.address} + {5'd0, i_item.length};
    assign room_start = 21'(sfcs_pkg::PageBytes)
        - 21'(i_item.address[sfcs_pkg::PageBits-1:0]);
    assign room_cur = 21'(sfcs_pkg::PageBytes)
        - 21'(r_addr[sfcs_pkg::PageBits-1:0]);

    function automatic sfcs_pkg::t_result mk(input logic [1:0] k, input logic [7:0] sb,
                                             input logic e, input logic [7:0] rb,
                                             input logic [1:0] st);
        sfcs_pkg::t_result r;
        r.kind = k; r.spi_byte = sb; r.eot = e; r.read_byte = rb; r.status = st;
        return r;
    endfunction

    always_comb begin
        n_phase = r_phase; n_op = r_op; n_addr = r_addr; n_rem = r_rem;
        n_chunk = r_chunk; n_hdr = r_hdr; n_poll = r_poll; n_wel = r_wel;
        res[0] = '0; res[1] = '0; res[2] = '0;
        cnt = 2'd0;
        if (take) begin
            case (i_item.command)
                sfcs_pkg::CMD_READ, sfcs_pkg::CMD_PROG, sfcs_pkg::CMD_ERASE: begin
                    if (r_phase == sfcs_pkg::PH_IDLE) begin
                        cnt = 2'd1;
                        if (end_addr > 25'(sfcs_pkg::ChipBytes)) begin
                            res[0] = mk(sfcs_pkg::KIND_DONE, 8'd0, 1'b0, 8'd0,
                                        sfcs_pkg::ST_RANGE);
                        end else if (i_item.length == 20'd0) begin
                            res[0] = mk(sfcs_pkg::KIND_DONE, 8'd0, 1'b0, 8'd0,
                                        sfcs_pkg::ST_OK);
                        end else begin
                            n_op   = i_item.command[1:0];
                            n_addr = i_item.address;
                            n_rem  = i_item.length;
                            n_hdr  = 2'd0;
                            if (i_item.command == sfcs_pkg::CMD_READ) begin
                                res[0]  = mk(sfcs_pkg::KIND_SPI, sfcs_pkg::SPI_READ, 1'b0,
                                             8'd0, sfcs_pkg::ST_OK);
                                n_phase = sfcs_pkg::PH_HDR;
                            end else begin
                                n_chunk = ({1'b0, i_item.length} < room_start) ?
                                    sfcs_pkg::ChunkW'(i_item.length) :
                                    sfcs_pkg::ChunkW'(room_start);
                                res[0]  = mk(sfcs_pkg::KIND_SPI, sfcs_pkg::SPI_WREN, 1'b1,
                                             8'd0, sfcs_pkg::ST_OK);
                                n_phase = sfcs_pkg::PH_WREN;
                            end
                        end
                    end
                end
                sfcs_pkg::CMD_DATA: begin
                    if (r_phase == sfcs_pkg::PH_PAYLOAD) begin
                        cnt = 2'd1;
                        res[0] = mk(sfcs_pkg::KIND_SPI, i_item.data,
                                    r_chunk <= sfcs_pkg::ChunkW'(1), 8'd0, sfcs_pkg::ST_OK);
                        n_phase = sfcs_pkg::PH_PDATA;
                    end
                end
                sfcs_pkg::CMD_TICK: begin
                    if (r_phase == sfcs_pkg::PH_POLLWAIT || r_phase == sfcs_pkg::PH_PROGWAIT)
                    begin
                        cnt = 2'd1;
                        res[0] = mk(sfcs_pkg::KIND_SPI, sfcs_pkg::SPI_RDSR, 1'b0, 8'd0,
                                    sfcs_pkg::ST_OK);
                        if (r_phase == sfcs_pkg::PH_PROGWAIT) begin
                            n_poll = 16'd0;
                            n_wel  = 1'b0;
                        end
                        n_phase = sfcs_pkg::PH_POLLCMD;
                    end
                end
                sfcs_pkg::CMD_REPLY: begin
                    case (r_phase)
                        sfcs_pkg::PH_HDR: begin
                            cnt = 2'd1;
                            if (r_hdr != 2'd3) begin
                                n_hdr = r_hdr + 2'd1;
                                case (r_hdr)
                                    2'd0:    res[0].spi_byte = r_addr[23:16];
                                    2'd1:    res[0].spi_byte = r_addr[15:8];
                                    default: res[0].spi_byte = r_addr[7:0];
                                endcase
                                res[0].kind = sfcs_pkg::KIND_SPI;
                                res[0].eot  = (r_op == sfcs_pkg::OP_ERASE) && (r_hdr == 2'd2);
                            end else if (r_op == sfcs_pkg::OP_READ) begin
                                res[0] = mk(sfcs_pkg::KIND_SPI, sfcs_pkg::SPI_DUMMY,
                                            r_rem == 20'd1, 8'd0, sfcs_pkg::ST_OK);
                                n_phase = sfcs_pkg::PH_RDATA;
                            end else if (r_op == sfcs_pkg::OP_PROG) begin
                                res[0] = mk(sfcs_pkg::KIND_WANT, 8'd0, 1'b0, 8'd0,
                                            sfcs_pkg::ST_OK);
                                n_phase = sfcs_pkg::PH_PAYLOAD;
                            end else begin
                                n_addr = r_addr + 24'(sfcs_pkg::SectorBytes);
                                n_rem  = (r_rem > 20'(sfcs_pkg::SectorBytes)) ?
                                    r_rem - 20'(sfcs_pkg::SectorBytes) : 20'd0;
                                n_poll = 16'd0;
                                n_wel  = 1'b0;
                                res[0] = mk(sfcs_pkg::KIND_SPI, sfcs_pkg::SPI_RDSR, 1'b0,
                                            8'd0, sfcs_pkg::ST_OK);
                                n_phase = sfcs_pkg::PH_POLLCMD;
                            end
                        end
                        sfcs_pkg::PH_RDATA: begin
                            cnt = 2'd2;
                            res[0] = mk(sfcs_pkg::KIND_RD, 8'd0, 1'b0, i_item.data,
                                        sfcs_pkg::ST_OK);
                            n_rem  = (r_rem != 20'd0) ? r_rem - 20'd1 : 20'd0;
                            n_addr = r_addr + 24'd1;
                            if (r_rem > 20'd1) begin
                                res[1] = mk(sfcs_pkg::KIND_SPI, sfcs_pkg::SPI_DUMMY,
                                            r_rem == 20'd2, 8'd0, sfcs_pkg::ST_OK);
                            end else begin
                                res[1] = mk(sfcs_pkg::KIND_DONE, 8'd0, 1'b0, 8'd0,
                                            sfcs_pkg::ST_OK);
                                n_phase = sfcs_pkg::PH_IDLE;
                            end
                        end
                        sfcs_pkg::PH_PDATA: begin
                            n_chunk = (r_chunk != '0) ? r_chunk - sfcs_pkg::ChunkW'(1) : '0;
                            n_rem   = (r_rem != 20'd0) ? r_rem - 20'd1 : 20'd0;
                            n_addr  = r_addr + 24'd1;
                            if (r_chunk > sfcs_pkg::ChunkW'(1)) begin
                                cnt = 2'd1;
                                res[0] = mk(sfcs_pkg::KIND_WANT, 8'd0, 1'b0, 8'd0,
                                            sfcs_pkg::ST_OK);
                                n_phase = sfcs_pkg::PH_PAYLOAD;
                            end else begin
                                n_phase = sfcs_pkg::PH_PROGWAIT;
                            end
                        end
                        sfcs_pkg::PH_WREN: begin
                            cnt = 2'd1;
                            n_poll = 16'd0;
                            n_wel  = 1'b1;
                            res[0] = mk(sfcs_pkg::KIND_SPI, sfcs_pkg::SPI_RDSR, 1'b0, 8'd0,
                                        sfcs_pkg::ST_OK);
                            n_phase = sfcs_pkg::PH_POLLCMD;
                        end
                        sfcs_pkg::PH_POLLCMD: begin
                            cnt = 2'd1;
                            res[0] = mk(sfcs_pkg::KIND_SPI, sfcs_pkg::SPI_DUMMY, 1'b1, 8'd0,
                                        sfcs_pkg::ST_OK);
                            n_phase = sfcs_pkg::PH_POLLDATA;
                        end
                        sfcs_pkg::PH_POLLDATA: begin
                            if ((r_wel && (i_item.data & sfcs_pkg::BIT_WEL) != 8'd0) ||
                                (!r_wel && (i_item.data & sfcs_pkg::BIT_WIP) == 8'd0)) begin
                                cnt = 2'd1;
                                if (r_wel) begin
                                    if (r_op == sfcs_pkg::OP_PROG) begin
                                        n_chunk = ({1'b0, r_rem} < room_cur) ?
                                            sfcs_pkg::ChunkW'(r_rem) :
                                            sfcs_pkg::ChunkW'(room_cur);
                                    end
                                    n_hdr = 2'd0;
                                    res[0] = mk(sfcs_pkg::KIND_SPI,
                                        (r_op == sfcs_pkg::OP_PROG) ? sfcs_pkg::SPI_PROG
                                                                    : sfcs_pkg::SPI_SE,
                                        1'b0, 8'd0, sfcs_pkg::ST_OK);
                                    n_phase = sfcs_pkg::PH_HDR;
                                end else if (r_rem != 20'd0) begin
                                    res[0] = mk(sfcs_pkg::KIND_SPI, sfcs_pkg::SPI_WREN, 1'b1,
                                                8'd0, sfcs_pkg::ST_OK);
                                    n_phase = sfcs_pkg::PH_WREN;
                                end else begin
                                    res[0] = mk(sfcs_pkg::KIND_DONE, 8'd0, 1'b0, 8'd0,
                                                sfcs_pkg::ST_OK);
                                    n_phase = sfcs_pkg::PH_IDLE;
                                end
                            end else begin
                                n_poll = poll_inc[15:0];
                                if (poll_inc[15:0] >= limit_eff) begin
                                    cnt = 2'd1;
                                    res[0] = mk(sfcs_pkg::KIND_DONE, 8'd0, 1'b0, 8'd0,
                                                sfcs_pkg::ST_TIMEOUT);
                                    n_phase = sfcs_pkg::PH_IDLE;
                                end else begin
                                    n_phase = sfcs_pkg::PH_POLLWAIT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_push          = take && (cnt != 2'd0);
    assign o_bundle.count  = cnt;
    assign o_bundle.r0     = res[0];
    assign o_bundle.r1     = res[1];
    assign o_bundle.r2     = res[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfcs_pkg::PH_IDLE;
            r_op    <= '0; r_addr <= '0; r_rem <= '0; r_chunk <= '0;
            r_hdr   <= '0; r_poll <= '0; r_wel <= 1'b0;
            r_limit <= sfcs_pkg::POLL_RESET;
        end else begin
            r_phase <= n_phase; r_op <= n_op; r_addr <= n_addr; r_rem <= n_rem;
            r_chunk <= n_chunk; r_hdr <= n_hdr; r_poll <= n_poll; r_wel <= n_wel;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end
endmodule

[sv/sfcs_back.sv]
// Back part: a bundle queue and an unroller that sends one result per transaction.
module sfcs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sfcs_pkg::t_bundle i_bundle,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output sfcs_pkg::t_result o_result,
    output logic              o_last
);
    sfcs_pkg::t_bundle r_mem [sfcs_pkg::QDepth];
    logic [sfcs_pkg::QAddrW-1:0] r_wp, r_rp;
    logic [sfcs_pkg::QAddrW:0]   r_cnt;
    logic [1:0] r_sub;
    sfcs_pkg::t_bundle head;
    logic pop, done_one;

    assign head     = r_mem[r_rp];
    assign o_full   = (r_cnt == (sfcs_pkg::QAddrW+1)'(sfcs_pkg::QDepth));
    assign o_valid  = (r_cnt != '0);
    assign o_last   = (r_sub == head.count - 2'd1);
    assign done_one = o_valid && i_ready;
    assign pop      = done_one && o_last;

    always_comb begin
        case (r_sub)
            2'd0:    o_result = head.r0;
            2'd1:    o_result = head.r1;
            default: o_result = head.r2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_sub <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp  <= r_rp + 1'b1;
                r_sub <= '0;
            end else if (done_one) begin
                r_sub <= r_sub + 2'd1;
            end
            r_cnt <= r_cnt + (sfcs_pkg::QAddrW+1)'(i_push) - (sfcs_pkg::QAddrW+1)'(pop);
        end
    end
endmodule

[sv/spi_flash_command_sequencer.sv]
// Top level of the SPI flash command sequencer.
// Channel   Direction  Payload
// s_axis    in         tdata: command, address, length, data
// m_axis    out        tdata: spi_byte, end_of_transfer, read_byte, status; tuser kind; tlast
// cfg       in         poll_limit, write only
// When an item is taken, the state machine decides all its results at once.
// Results queue as bundles of up to three and leave one per cycle while m_axis_tready is high.
// The bundle queue holds four; input is stalled only while it is full.
// Reset is synchronous and active low; poll_limit resets to 10000.
module spi_flash_command_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // command[2:0], address[26:3], length[46:27], data[54:47]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // spi_byte[7:0], end_of_transfer[8], read_byte[16:9],
                                        // status[18:17]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast
);
    sfcs_pkg::t_item   item;
    sfcs_pkg::t_bundle bundle;
    sfcs_pkg::t_result res;
    logic push, full;

    assign item.command = s_axis_tdata[2:0];
    assign item.address = s_axis_tdata[26:3];
    assign item.length  = s_axis_tdata[46:27];
    assign item.data    = s_axis_tdata[54:47];

    sfcs_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(item),
        .o_push(push), .o_bundle(bundle), .i_full(full)
    );

    sfcs_back u_back (
        .i_clk, .i_rst_n, .i_push(push), .i_bundle(bundle), .o_full(full),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_result(res),
        .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, res.status, res.read_byte, res.eot, res.spi_byte};
    assign m_axis_tuser = res.kind;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full)) else $error("bundle pushed into a full queue");
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> bundle.count != 2'd0) else $error("empty bundle pushed");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == sfcs_pkg::KIND_DONE) |-> m_axis_tlast)
        else $error("done result not last");
endmodule
